// ===== rtl/core/rect_occupancy_grid_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle occupancy grid allocator
// Shared concurrent check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RECT_OCCUPANCY_GRID_ALLOCATOR_UNIT_MACROS_SVH
`define RECT_OCCUPANCY_GRID_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define ROGAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rogau: same-cycle check failed");

// next-cycle implication
`define ROGAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rogau: next-cycle check failed");

`endif

// ===== rtl/core/rogau_pkg.sv =====
// ----------------------------------------------------------------------------
// rogau_pkg
// Shared codes, widths and the cell control word of the grid allocator.
// ----------------------------------------------------------------------------
package rogau_pkg;

  localparam int POSW = 8;  // linear cell position
  localparam int SZW  = 5;  // rectangle width/height
  localparam int DIMW = 7;  // active grid size, up to 127
  localparam int CFGW = 5;  // configuration register width

  typedef enum logic [2:0] {
    MODE_FIND  = 3'd0,
    MODE_PLACE = 3'd1,
    MODE_FREE  = 3'd2,
    MODE_TEST  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    C_NOP,
    C_LOAD_OCC,
    C_LOAD_SEED,
    C_SHIFT,
    C_SHIFT_ACC,
    C_COPY,
    C_FIT,
    C_SET_RECT,
    C_CLR_MASK,
    C_CLR_ALL
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              dir_up;
    logic [POSW-1:0]   pos;
    logic [POSW-1:0]   row0;
    logic [DIMW-1:0]   col0;
    logic [SZW-1:0]    h;
    logic [SZW-1:0]    w;
    logic [SZW-1:0]    ew;
    logic [DIMW-1:0]   rows;
    logic [DIMW-1:0]   cols;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_HORZ,
    S_COPY,
    S_VERT,
    S_EVAL,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_e;

endpackage

// ===== rtl/core/rect_occupancy_grid_allocator_unit.sv =====
// Rectangle occupancy allocator over a MAX_COLS x MAX_ROWS grid of one-bit
// cells, one result word per request word. A find, place, test or free
// request first splits the position into row and column in a bit-serial
// divider. Find, place and test then OR the rectangle out of the cell chain
// with one shift per cycle; find adds a first-fit scan along the chain. Free
// takes the same shift walk plus an evaluate and a write step; clear goes
// straight to the write. After reset and after every grid_cols write the cell
// labels ripple through the chain, and no request is taken until that ripple
// time has run out.
// ----------------------------------------------------------------------------
// rect_occupancy_grid_allocator_unit
// Top level: APB registers, request sequencer, divider and the cell chain.
// ----------------------------------------------------------------------------
`include "rect_occupancy_grid_allocator_unit_macros.svh"

module rect_occupancy_grid_allocator_unit import rogau_pkg::*; #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      mode_i,
  input  logic [7:0]      cell_pos_i,
  input  logic [4:0]      rect_w_i,
  input  logic [4:0]      rect_h_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            ok_o,
  output logic [7:0]      found_pos_o
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int RW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RDW   = $clog2(MAX_ROWS + 1);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int PW    = ((RW > POSW) ? RW : POSW) + 1;

  // configuration
  logic [CFGW-1:0] cols_cfg_q, rows_cfg_q;
  logic [CW-1:0]   cols_eff, cols_m1;
  logic [RDW-1:0]  rows_eff;
  logic            cfg_wr;
  logic [SW-1:0]   settle_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CFGW'(16);
      rows_cfg_q <= CFGW'(16);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COLS) cols_cfg_q <= pwdata[CFGW-1:0];
      else                      rows_cfg_q <= pwdata[CFGW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_COLS) prdata = {{(32-CFGW){1'b0}}, cols_cfg_q};
    else                      prdata = {{(32-CFGW){1'b0}}, rows_cfg_q};
  end

  // zero acts as one, anything past the maximum as the maximum
  always_comb begin
    if (cols_cfg_q == '0)                   cols_eff = CW'(1);
    else if (8'(cols_cfg_q) > 8'(MAX_COLS)) cols_eff = CW'(MAX_COLS);
    else                                    cols_eff = CW'(cols_cfg_q);
    if (rows_cfg_q == '0)                   rows_eff = RDW'(1);
    else if (8'(rows_cfg_q) > 8'(MAX_ROWS)) rows_eff = RDW'(MAX_ROWS);
    else                                    rows_eff = RDW'(rows_cfg_q);
    cols_m1 = cols_eff - CW'(1);
  end

  // label ripple time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SW'(CELLS);
    end else if (cfg_wr && paddr[2] == REG_COLS) begin
      settle_q <= SW'(CELLS);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - SW'(1);
    end
  end

  // request registers
  state_e         st_q, st_d;
  logic [2:0]     mode_q;
  logic [POSW-1:0] pos_q;
  logic [SZW-1:0] w_q, h_q, ew;
  logic [SZW-1:0] k_q, k_d, y_q, y_d;
  logic [CW-1:0]  s_q, s_d;
  logic [RW-1:0]  p_q, p_d;
  logic           res_ok_q, res_ok_d;
  logic [POSW-1:0] res_pos_q, res_pos_d;
  logic           out_valid_q, ok_q;
  logic [POSW-1:0] found_q;
  logic           in_acc, load_out, div_start, div_busy;
  logic [POSW-1:0] div_quo;
  logic [CW-1:0]  div_rem;
  cell_ctrl_t     ctrl;
  cell_op_e       op;
  logic           inb, size_ok, b_at_pos;
  logic [PW-1:0]  pos_ext;
  logic [RW-1:0]  pos_idx;

  assign in_stall_o = !(st_q == S_IDLE && settle_q == '0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ew         = (w_q == '0) ? SZW'(1) : w_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      pos_q  <= cell_pos_i;
      w_q    <= rect_w_i;
      h_q    <= rect_h_i;
    end
  end

  rogau_div #(.DW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cell_pos_i),
    .divisor_i  (cols_eff),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // cell chain
  logic [CELLS-1:0] avec, bvec;
  logic [CELLS+1:0] a_ext;
  logic [RW-1:0]    lab_r [CELLS+1];
  logic [CLW-1:0]   lab_c [CELLS+1];

  assign a_ext[0]       = 1'b0;
  assign a_ext[CELLS+1] = 1'b0;
  assign lab_r[0]       = '0;
  assign lab_c[0]       = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    assign a_ext[i+1] = avec[i];
    rogau_cell #(.IDX(i), .CELLS(CELLS), .MAX_COLS(MAX_COLS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .a_up_i  (a_ext[i]),
      .a_dn_i  (a_ext[i+2]),
      .lab_r_i (lab_r[i]),
      .lab_c_i (lab_c[i]),
      .a_o     (avec[i]),
      .b_o     (bvec[i]),
      .lab_r_o (lab_r[i+1]),
      .lab_c_o (lab_c[i+1])
    );
  end

  always_comb begin
    pos_ext  = PW'(pos_q);
    pos_idx  = pos_ext[RW-1:0];
    b_at_pos = (pos_ext < PW'(CELLS)) && bvec[pos_idx];
    inb      = (9'(div_quo) + 9'(h_q) <= 9'(rows_eff))
               && ((w_q == '0) || (8'(div_rem) + 8'(w_q) <= 8'(cols_eff)));
    size_ok  = (8'(w_q) <= 8'(cols_eff)) && (8'(h_q) <= 8'(rows_eff));
  end

  always_comb begin
    ctrl.op     = op;
    ctrl.dir_up = (mode_q == MODE_FREE);
    ctrl.pos    = pos_q;
    ctrl.row0   = div_quo;
    ctrl.col0   = DIMW'(div_rem);
    ctrl.h      = h_q;
    ctrl.w      = w_q;
    ctrl.ew     = ew;
    ctrl.rows   = DIMW'(rows_eff);
    ctrl.cols   = DIMW'(cols_eff);
  end

  // sequencer
  always_comb begin
    st_d      = st_q;
    op        = C_NOP;
    k_d       = k_q;
    y_d       = y_q;
    s_d       = s_q;
    p_d       = p_q;
    res_ok_d  = res_ok_q;
    res_pos_d = res_pos_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          res_pos_d = '0;
          res_ok_d  = 1'b0;
          priority if (mode_i == MODE_CLEAR) begin
            st_d = S_APPLY;
          end else if (mode_i == MODE_FIND || mode_i == MODE_PLACE ||
                       mode_i == MODE_FREE || mode_i == MODE_TEST) begin
            div_start = 1'b1;
            st_d      = S_DIV;
          end else begin
            st_d = S_RESP;
          end
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          priority if (mode_q == MODE_FIND && !size_ok) begin
            st_d = S_RESP;
          end else if (mode_q == MODE_FREE &&
                       (9'(div_quo) >= 9'(rows_eff) || h_q == '0)) begin
            // nothing to clear
            res_ok_d = 1'b1;
            st_d     = S_RESP;
          end else begin
            st_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        op   = (mode_q == MODE_FREE) ? C_LOAD_SEED : C_LOAD_OCC;
        k_d  = SZW'(1);
        st_d = (ew > SZW'(1)) ? S_HORZ : S_COPY;
      end
      S_HORZ: begin
        op  = C_SHIFT_ACC;
        k_d = k_q + SZW'(1);
        if (k_q == ew - SZW'(1)) st_d = S_COPY;
      end
      S_COPY: begin
        op   = C_COPY;
        y_d  = SZW'(1);
        s_d  = '0;
        st_d = (h_q > SZW'(1)) ? S_VERT : S_EVAL;
      end
      S_VERT: begin
        // one row stride is grid_cols single-cell shifts
        if (s_q == cols_m1) begin
          op  = C_SHIFT_ACC;
          s_d = '0;
          y_d = y_q + SZW'(1);
          if (y_q == h_q - SZW'(1)) st_d = S_EVAL;
        end else begin
          op  = C_SHIFT;
          s_d = s_q + CW'(1);
        end
      end
      S_EVAL: begin
        unique case (mode_q)
          MODE_FIND: begin
            op   = C_FIT;
            p_d  = '0;
            st_d = S_SCAN;
          end
          MODE_PLACE: begin
            res_ok_d = inb && ((h_q == '0) || !b_at_pos);
            st_d = (res_ok_d && h_q != '0) ? S_APPLY : S_RESP;
          end
          MODE_TEST: begin
            res_ok_d = inb && ((h_q == '0) || !b_at_pos);
            st_d     = S_RESP;
          end
          default: st_d = S_APPLY;
        endcase
      end
      S_SCAN: begin
        priority if (avec[0]) begin
          res_ok_d  = 1'b1;
          res_pos_d = POSW'(p_q);
          st_d      = S_RESP;
        end else if (p_q == RW'(CELLS - 1)) begin
          st_d = S_RESP;
        end else begin
          op  = C_SHIFT;
          p_d = p_q + RW'(1);
        end
      end
      S_APPLY: begin
        unique case (mode_q)
          MODE_CLEAR: op = C_CLR_ALL;
          MODE_FREE:  op = C_CLR_MASK;
          default:    op = C_SET_RECT;
        endcase
        res_ok_d = 1'b1;
        st_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    y_q       <= y_d;
    s_q       <= s_d;
    p_q       <= p_d;
    res_ok_q  <= res_ok_d;
    res_pos_q <= res_pos_d;
    if (load_out) begin
      ok_q    <= res_ok_q;
      found_q <= res_pos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign found_pos_o = found_q;

  `ROGAU_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, st_q != S_IDLE)
  `ROGAU_ASSERT_IMPL(a_nofit_pos_zero, clk_i, rst_ni, out_valid_o && !ok_o, found_pos_o == '0)
  `ROGAU_ASSERT_NEXT(a_apply_then_resp, clk_i, rst_ni, st_q == S_APPLY, st_q == S_RESP)
  `ROGAU_ASSERT_NEXT(a_resp_loads_out, clk_i, rst_ni, load_out, out_valid_o)

endmodule

// ===== rtl/core/rogau_cell.sv =====
// ----------------------------------------------------------------------------
// rogau_cell
// One grid cell: occupancy bit, row/column label and two shift bits.
// ----------------------------------------------------------------------------
module rogau_cell import rogau_pkg::*; #(
  parameter int IDX      = 0,
  parameter int CELLS    = 256,
  parameter int MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cell_ctrl_t                           ctrl_i,
  input  logic                                 a_up_i,
  input  logic                                 a_dn_i,
  input  logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0]       lab_r_i,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] lab_c_i,
  output logic                                 a_o,
  output logic                                 b_o,
  output logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0]       lab_r_o,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] lab_c_o
);

  localparam int RW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW  = ((RW > POSW) ? RW : POSW) + 2;

  logic          occ_q, occ_d;
  logic          a_q, a_d, b_q, b_d;
  logic [RW-1:0]  lab_r_q, lab_r_d;
  logic [CLW-1:0] lab_c_q, lab_c_d;
  logic [DIMW:0]  c_inc;
  logic          nbr, fit, in_rect, row_ok, seed;
  logic [EW-1:0] r_e, c_e;

  // labels ripple one cell per cycle after a column count change
  always_comb begin
    c_inc = (DIMW+1)'(lab_c_i) + (DIMW+1)'(1);
    if (IDX == 0) begin
      lab_r_d = '0;
      lab_c_d = '0;
    end else if (c_inc >= (DIMW+1)'(ctrl_i.cols)) begin
      lab_r_d = lab_r_i + RW'(1);
      lab_c_d = '0;
    end else begin
      lab_r_d = lab_r_i;
      lab_c_d = CLW'(c_inc);
    end
  end

  always_comb begin
    r_e    = EW'(lab_r_q);
    c_e    = EW'(lab_c_q);
    nbr    = ctrl_i.dir_up ? a_up_i : a_dn_i;
    row_ok = r_e < EW'(ctrl_i.rows);
    seed   = EW'(IDX) == EW'(ctrl_i.pos);
    fit    = row_ok
             && (r_e + EW'(ctrl_i.h) <= EW'(ctrl_i.rows))
             && ((ctrl_i.w == '0) || (c_e + EW'(ctrl_i.w) <= EW'(ctrl_i.cols)))
             && ((ctrl_i.h == '0) || !b_q);
    in_rect = (r_e >= EW'(ctrl_i.row0))
              && (r_e < EW'(ctrl_i.row0) + EW'(ctrl_i.h))
              && (c_e >= EW'(ctrl_i.col0))
              && (c_e < EW'(ctrl_i.col0) + EW'(ctrl_i.ew));
  end

  always_comb begin
    occ_d = occ_q;
    a_d   = a_q;
    b_d   = b_q;
    unique case (ctrl_i.op)
      C_NOP:       ;
      C_LOAD_OCC:  begin a_d = occ_q; b_d = occ_q; end
      C_LOAD_SEED: begin a_d = seed;  b_d = seed;  end
      C_SHIFT:     a_d = nbr;
      C_SHIFT_ACC: begin a_d = nbr;   b_d = b_q | nbr; end
      C_COPY:      a_d = b_q;
      C_FIT:       a_d = fit;
      C_SET_RECT:  if (in_rect) occ_d = 1'b1;
      C_CLR_MASK:  if (b_q && row_ok) occ_d = 1'b0;
      C_CLR_ALL:   if (row_ok) occ_d = 1'b0;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      lab_r_q <= '0;
      lab_c_q <= '0;
    end else begin
      occ_q   <= occ_d;
      lab_r_q <= lab_r_d;
      lab_c_q <= lab_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o     = a_q;
  assign b_o     = b_q;
  assign lab_r_o = lab_r_q;
  assign lab_c_o = lab_c_q;

endmodule

// ===== rtl/core/rogau_div.sv =====
// ----------------------------------------------------------------------------
// rogau_div
// Restoring divider, one quotient bit per cycle: position / columns.
// ----------------------------------------------------------------------------
module rogau_div import rogau_pkg::*; #(
  parameter int DW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [POSW-1:0] dividend_i,
  input  logic [DW-1:0]   divisor_i,
  output logic            busy_o,
  output logic [POSW-1:0] quo_o,
  output logic [DW-1:0]   rem_o
);

  localparam int CNTW = $clog2(POSW);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [POSW-1:0] quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW:0]     rem_sh;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[POSW-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(POSW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(rem_sh - {1'b0, divisor_i}) : DW'(rem_sh);
      quo_q <= {quo_q[POSW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
